@@ hw/rtl/bpg_pkg.sv @@
// Shared types and constants for the burst pulse generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bpg_pkg;

   localparam int CHANNELS = 4;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OUT_CH   = (CHANNELS < 4) ? CHANNELS : 4;

   // request opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [6:0] DUTY_MAX = 7'd100;

   // arithmetic widths
   localparam int WAIT_W = 24;
   localparam int X_W    = 23;                // period * duty < 2^23
   localparam int Q_W    = 17;
   localparam int PROD_W = 40;                // 24 x 16 product
   localparam int RECIP_SH = 22;
   localparam logic [15:0] RECIP_K = 16'd41943; // floor(2^22 / 100)
   localparam logic [15:0] HUNDRED = 16'd100;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_TOGGLE = 2'd1,
      PH_SLEEP  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_VISIT,
      SQ_SCALE,
      SQ_BACK,
      SQ_FIX,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MS_PLAIN,
      MS_RECIP,
      MS_HUNDRED
   } mul_sel_type;

   typedef struct packed {
      logic        en;
      mul_sel_type sel;
      logic [23:0] opa;
      logic [7:0]  opb;
   } mul_ctl_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  channel;
      logic [15:0] period;
      logic [6:0]  duty;
      logic [6:0]  pulse_count;
      logic [7:0]  sleep_periods;
      logic [7:0]  repeat_req;
   } req_type;

   typedef struct packed {
      logic [3:0] pin_levels;
      logic [3:0] active_mask;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic              pin;
      logic [WAIT_W-1:0] wait_left;
      logic [7:0]        tdone;
      logic [7:0]        bdone;
      logic [15:0]       period;
      logic [6:0]        duty;
      logic [6:0]        toggles;
      logic [7:0]        sleep_n;
      logic [7:0]        rep;
   } chan_type;

endpackage

`default_nettype wire

@@ hw/rtl/burst_pulse_generator.sv @@
// Burst pulse generator top level: request handling, channel sequencer, result register.
// Depends on bpg_pkg and bpg_mul_unit.
//
// Each request returns one response with all pin levels and active flags. A start or
// stop request goes from idle straight to the done state. A tick request visits the
// channels in turn: an idle or still-counting channel is handled in the visit state
// alone, a channel entering sleep in visit and scale, and a channel that ends a pulse
// half in visit, scale, back and fix (a period times duty product, a reciprocal multiply
// for the divide by hundred, and a back-multiply with one correction). The single
// shared 24 x 16 multiplier serves all of these steps. A new request is taken as soon as the
// sequencer is back in idle, even while the previous response still waits.
`default_nettype none

module burst_pulse_generator import bpg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   seq_state_type     state_ff, state_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic              sleep_path_ff, sleep_path_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Q_W-1:0]    q0_ff, q0_in;
   chan_type          chan_ff [CHANNELS];
   chan_type          cur, chan_in;
   logic              wr_en;
   logic [CH_W-1:0]   rd_idx;
   logic              advance;
   logic              rsp_load;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_in;
   mul_ctl_type       mul_ctl;
   logic [PROD_W-1:0] prod;

   bpg_mul_unit u_mul (
      .clock (clock),
      .ctl   (mul_ctl),
      .prod  (prod)
   );

   assign req_ready = (state_ff == SQ_IDLE);
   assign rd_idx    = (state_ff == SQ_IDLE) ? CH_W'(req_data.channel) : ch_ff;
   assign cur       = chan_ff[rd_idx];

   always_comb begin
      logic [WAIT_W-1:0] wl;
      logic [7:0]        td;
      logic [7:0]        bd;
      logic [X_W:0]      r;
      logic [Q_W-1:0]    q;

      state_in      = state_ff;
      ch_in         = ch_ff;
      sleep_path_in = sleep_path_ff;
      x_in          = x_ff;
      q0_in         = q0_ff;
      chan_in       = cur;
      wr_en         = 1'b0;
      advance       = 1'b0;
      rsp_load      = 1'b0;
      mul_ctl       = '{en: 1'b0, sel: MS_PLAIN, opa: '0, opb: '0};
      wl            = cur.wait_left - WAIT_W'(cur.wait_left != '0);
      td            = cur.tdone + 8'd1;
      bd            = cur.bdone + 8'd1;
      r             = {1'b0, x_ff} - prod[X_W:0];
      q             = q0_ff + Q_W'(r >= (X_W + 1)'(100));

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_TICK) begin
                  ch_in    = '0;
                  state_in = SQ_VISIT;
               end else begin
                  state_in = SQ_DONE;
                  if (int'(req_data.channel) < CHANNELS) begin
                     if (req_data.op == OP_START) begin
                        wr_en             = 1'b1;
                        chan_in.period    = req_data.period;
                        chan_in.duty      = (req_data.duty > DUTY_MAX) ? DUTY_MAX
                                                                       : req_data.duty;
                        chan_in.toggles   = req_data.pulse_count;
                        chan_in.sleep_n   = req_data.sleep_periods;
                        chan_in.rep       = req_data.repeat_req;
                        chan_in.phase     = PH_TOGGLE;
                        chan_in.tdone     = '0;
                        chan_in.bdone     = '0;
                        chan_in.wait_left = '0;
                     end else if (req_data.op == OP_STOP) begin
                        wr_en         = 1'b1;
                        chan_in.phase = PH_IDLE;
                        chan_in.pin   = 1'b0;
                     end
                  end
               end
            end
         end

         SQ_VISIT: begin
            if (cur.phase == PH_IDLE) begin
               advance = 1'b1;
            end else if (wl != '0) begin
               wr_en             = 1'b1;
               chan_in.wait_left = wl;
               advance           = 1'b1;
            end else if (cur.phase == PH_TOGGLE) begin
               // edge: flip the pin, then size the next wait on the shared multiplier
               wr_en             = 1'b1;
               chan_in.pin       = ~cur.pin;
               chan_in.wait_left = '0;
               mul_ctl.en        = 1'b1;
               mul_ctl.sel       = MS_PLAIN;
               mul_ctl.opa       = 24'(cur.period);
               state_in          = SQ_SCALE;
               if (td >= {cur.toggles, 1'b0}) begin
                  chan_in.tdone = '0;
                  chan_in.phase = PH_SLEEP;
                  sleep_path_in = 1'b1;
                  mul_ctl.opb   = cur.sleep_n;
               end else begin
                  chan_in.tdone = td;
                  sleep_path_in = 1'b0;
                  mul_ctl.opb   = td[0] ? 8'(DUTY_MAX - cur.duty) : {1'b0, cur.duty};
               end
            end else begin
               // wake from sleep: count the burst, stop when the repeat count is met
               wr_en             = 1'b1;
               chan_in.phase     = PH_TOGGLE;
               chan_in.wait_left = '0;
               advance           = 1'b1;
               if (cur.rep != '0) begin
                  chan_in.bdone = bd;
                  if (bd >= cur.rep) begin
                     chan_in.phase = PH_IDLE;
                  end
               end
            end
         end

         SQ_SCALE: begin
            if (sleep_path_ff) begin
               wr_en             = 1'b1;
               chan_in.wait_left = prod[WAIT_W-1:0];
               advance           = 1'b1;
            end else begin
               x_in        = prod[X_W-1:0];
               mul_ctl.en  = 1'b1;
               mul_ctl.sel = MS_RECIP;
               mul_ctl.opa = 24'(prod[X_W-1:0]);
               state_in    = SQ_BACK;
            end
         end

         SQ_BACK: begin
            // quotient estimate is exact or one low
            q0_in       = prod[RECIP_SH +: Q_W];
            mul_ctl.en  = 1'b1;
            mul_ctl.sel = MS_HUNDRED;
            mul_ctl.opa = 24'(prod[RECIP_SH +: Q_W]);
            state_in    = SQ_FIX;
         end

         SQ_FIX: begin
            wr_en             = 1'b1;
            chan_in.wait_left = WAIT_W'(q);
            advance           = 1'b1;
         end

         SQ_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = SQ_IDLE;
            end
         end

         default: state_in = SQ_IDLE;
      endcase

      if (advance) begin
         if (ch_ff == CH_W'(CHANNELS - 1)) begin
            state_in = SQ_DONE;
         end else begin
            ch_in    = ch_ff + CH_W'(1);
            state_in = SQ_VISIT;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      for (int c = 0; c < OUT_CH; c++) begin
         rsp_in.pin_levels[c]  = chan_ff[c].pin;
         rsp_in.active_mask[c] = (chan_ff[c].phase != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      sleep_path_ff <= sleep_path_in;
      x_ff          <= x_in;
      q0_ff         <= q0_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c].phase <= PH_IDLE;
            chan_ff[c].pin   <= 1'b0;
         end
      end else if (wr_en) begin
         chan_ff[rd_idx] <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bpg_mul_unit.sv @@
// Shared multiplier of the burst pulse generator, with registered product.
// Depends on bpg_pkg for the control struct and reciprocal constants.
`default_nettype none

module bpg_mul_unit import bpg_pkg::*; (
   input  wire logic              clock,
   input  wire mul_ctl_type       ctl,
   output logic [PROD_W-1:0]      prod
);

   logic [15:0]       opb_sel;
   logic [PROD_W-1:0] prod_ff;

   always_comb begin
      unique case (ctl.sel)
         MS_PLAIN:   opb_sel = {8'd0, ctl.opb};
         MS_RECIP:   opb_sel = RECIP_K;
         MS_HUNDRED: opb_sel = HUNDRED;
         default:    opb_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         prod_ff <= PROD_W'(ctl.opa) * PROD_W'(opb_sel);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bpg_checker.sv @@
// Port-level checks for the burst pulse generator, bound to the top level.
// Depends on bpg_pkg for the request and response structs.
`default_nettype none

module bpg_checker import bpg_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a waiting response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // the sequencer is busy in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on back-to-back cycles");

   // no response comes out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a response appears only as the sequencer returns to idle
   a_rsp_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response raised while sequencer busy");

endmodule

bind burst_pulse_generator bpg_checker u_bpg_checker (.*);

`default_nettype wire
